// ===== hw/rtl/msi_pkg.sv =====
// ---------------------------------------------------------------------------
// msi_pkg
// Shared types, constants and helpers for the motor safety interlock.
// ---------------------------------------------------------------------------
package msi_pkg;

    localparam int DATA_W     = 16;
    localparam int MAG_W      = DATA_W + 1;
    localparam int THR_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int MON_W      = 3;
    localparam int FAULT_W    = 4;
    localparam int ANGLE_W    = 21;

    // default tick counts and angle limit
    localparam int DEF_GRACE_TICKS      = 30;
    localparam int DEF_TREND_TICKS      = 30;
    localparam int DEF_STALL_TICKS      = 50;
    localparam int DEF_EXTREME_TICKS    = 250;
    localparam int DEF_SPIN_RESET_TICKS = 10;
    localparam int DEF_ANGLE_LIMIT_MDEG = 1080000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TARGET_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_SPEED_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TARGET_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_SPEED_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_DRIVE_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RATE_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTREME_RATE_MIN = 3'd7;

    // monitor enable bit positions
    localparam int MON_STOP  = 0;
    localparam int MON_STALL = 1;
    localparam int MON_SPIN  = 2;

    // register reset values
    localparam logic [MON_W-1:0] RST_MONITOR_ENABLE   = 3'd0;
    localparam logic [THR_W-1:0] RST_STOP_TARGET_MAX  = 15'd5;
    localparam logic [THR_W-1:0] RST_MOVING_SPEED_MIN = 15'd20;
    localparam logic [THR_W-1:0] RST_STALL_TARGET_MIN = 15'd50;
    localparam logic [THR_W-1:0] RST_STALL_SPEED_MAX  = 15'd5;
    localparam logic [THR_W-1:0] RST_STALL_DRIVE_MIN  = 15'd4800;
    localparam logic [THR_W-1:0] RST_SPIN_RATE_MIN    = 15'd3500;
    localparam logic [THR_W-1:0] RST_EXTREME_RATE_MIN = 15'd5000;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE    = 4'd0,
        FAULT_LINK    = 4'd1,
        FAULT_IMU     = 4'd2,
        FAULT_MAINT   = 4'd3,
        FAULT_NODECEL = 4'd4,
        FAULT_LSTALL  = 4'd5,
        FAULT_RSTALL  = 4'd6,
        FAULT_EXTREME = 4'd7,
        FAULT_SPIN    = 4'd8
    } t_fault;

    typedef struct packed {
        logic [MON_W-1:0] monitor_enable;
        logic [THR_W-1:0] stop_target_max;
        logic [THR_W-1:0] moving_speed_min;
        logic [THR_W-1:0] stall_target_min;
        logic [THR_W-1:0] stall_speed_max;
        logic [THR_W-1:0] stall_drive_min;
        logic [THR_W-1:0] spin_rate_min;
        logic [THR_W-1:0] extreme_rate_min;
    } t_cfg;

    typedef struct packed {
        logic                     run_switch;
        logic                     link_ok;
        logic                     imu_ok;
        logic                     maint_busy;
        logic signed [DATA_W-1:0] left_target;
        logic signed [DATA_W-1:0] right_target;
        logic signed [DATA_W-1:0] left_speed;
        logic signed [DATA_W-1:0] right_speed;
        logic signed [DATA_W-1:0] left_drive;
        logic signed [DATA_W-1:0] right_drive;
        logic signed [DATA_W-1:0] yaw_rate;
    } t_in_item;

    typedef struct packed {
        logic   drive_allowed;
        t_fault fault_code;
        logic   rearm_armed;
    } t_out_item;

    // magnitude at one extra bit, so the most negative code maps to 32768
    function automatic logic [MAG_W-1:0] mag16(input logic signed [DATA_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[DATA_W-1], v};
        return v[DATA_W-1] ? (MAG_W'(0) - ext) : ext;
    endfunction

endpackage

// ===== hw/rtl/msi_if.sv =====
// ---------------------------------------------------------------------------
// msi_in_if / msi_out_if
// Valid/ready channels for tick items and interlock results.
// ---------------------------------------------------------------------------
interface msi_in_if
    import msi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     run_switch;
    logic                     link_ok;
    logic                     imu_ok;
    logic                     maint_busy;
    logic signed [DATA_W-1:0] left_target;
    logic signed [DATA_W-1:0] right_target;
    logic signed [DATA_W-1:0] left_speed;
    logic signed [DATA_W-1:0] right_speed;
    logic signed [DATA_W-1:0] left_drive;
    logic signed [DATA_W-1:0] right_drive;
    logic signed [DATA_W-1:0] yaw_rate;

    modport source (
        output valid, run_switch, link_ok, imu_ok, maint_busy, left_target,
               right_target, left_speed, right_speed, left_drive, right_drive,
               yaw_rate,
        input  ready
    );
    modport sink (
        input  valid, run_switch, link_ok, imu_ok, maint_busy, left_target,
               right_target, left_speed, right_speed, left_drive, right_drive,
               yaw_rate,
        output ready
    );
endinterface

interface msi_out_if
    import msi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               drive_allowed;
    logic [FAULT_W-1:0] fault_code;
    logic               rearm_armed;

    modport source (
        output valid, drive_allowed, fault_code, rearm_armed,
        input  ready
    );
    modport sink (
        input  valid, drive_allowed, fault_code, rearm_armed,
        output ready
    );
endinterface

// ===== hw/rtl/msi_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// msi_cfg_regs
// Write-only configuration registers for the interlock thresholds.
// ---------------------------------------------------------------------------
module msi_cfg_regs
    import msi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.monitor_enable   <= RST_MONITOR_ENABLE;
            r_cfg.stop_target_max  <= RST_STOP_TARGET_MAX;
            r_cfg.moving_speed_min <= RST_MOVING_SPEED_MIN;
            r_cfg.stall_target_min <= RST_STALL_TARGET_MIN;
            r_cfg.stall_speed_max  <= RST_STALL_SPEED_MAX;
            r_cfg.stall_drive_min  <= RST_STALL_DRIVE_MIN;
            r_cfg.spin_rate_min    <= RST_SPIN_RATE_MIN;
            r_cfg.extreme_rate_min <= RST_EXTREME_RATE_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MONITOR_ENABLE:   r_cfg.monitor_enable   <= i_cfg_wdata[MON_W-1:0];
                CFG_STOP_TARGET_MAX:  r_cfg.stop_target_max  <= i_cfg_wdata;
                CFG_MOVING_SPEED_MIN: r_cfg.moving_speed_min <= i_cfg_wdata;
                CFG_STALL_TARGET_MIN: r_cfg.stall_target_min <= i_cfg_wdata;
                CFG_STALL_SPEED_MAX:  r_cfg.stall_speed_max  <= i_cfg_wdata;
                CFG_STALL_DRIVE_MIN:  r_cfg.stall_drive_min  <= i_cfg_wdata;
                CFG_SPIN_RATE_MIN:    r_cfg.spin_rate_min    <= i_cfg_wdata;
                CFG_EXTREME_RATE_MIN: r_cfg.extreme_rate_min <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/msi_core.sv =====
// ---------------------------------------------------------------------------
// msi_core
// Interlock state and one-tick update: trip logic, re-arm and the stop,
// stall and rotation monitors.
// ---------------------------------------------------------------------------
module msi_core
    import msi_pkg::*;
#(
    parameter int GRACE_TICKS      = DEF_GRACE_TICKS,
    parameter int TREND_TICKS      = DEF_TREND_TICKS,
    parameter int STALL_TICKS      = DEF_STALL_TICKS,
    parameter int EXTREME_TICKS    = DEF_EXTREME_TICKS,
    parameter int SPIN_RESET_TICKS = DEF_SPIN_RESET_TICKS,
    parameter int ANGLE_LIMIT_MDEG = DEF_ANGLE_LIMIT_MDEG
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int GRACE_W = $clog2(GRACE_TICKS + 1);
    localparam int TREND_W = $clog2(TREND_TICKS + 1);
    localparam int STALL_W = $clog2(STALL_TICKS + 1);
    localparam int EXT_W   = $clog2(EXTREME_TICKS + 1);
    localparam int SPIN_W  = $clog2(SPIN_RESET_TICKS + 1);
    localparam int PROD_W  = MAG_W + 4;

    localparam logic [GRACE_W-1:0] GRACE_END = GRACE_W'(GRACE_TICKS);
    localparam logic [TREND_W-1:0] TREND_END = TREND_W'(TREND_TICKS);
    localparam logic [STALL_W-1:0] STALL_END = STALL_W'(STALL_TICKS);
    localparam logic [EXT_W-1:0]   EXT_END   = EXT_W'(EXTREME_TICKS);
    localparam logic [SPIN_W-1:0]  SPIN_END  = SPIN_W'(SPIN_RESET_TICKS);
    localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(ANGLE_LIMIT_MDEG);

    typedef enum logic [1:0] {
        SPIN_NONE = 2'd0,
        SPIN_POS  = 2'd1,
        SPIN_NEG  = 2'd2
    } t_spin_dir;

    logic               r_allowed, n_allowed;
    logic               r_rearm, n_rearm;
    logic               r_switch_prev, n_switch_prev;
    t_fault             r_fault, n_fault;
    logic [GRACE_W-1:0] r_grace, n_grace;
    logic [TREND_W-1:0] r_trend, n_trend;
    logic [THR_W-1:0]   r_ref_speed, n_ref_speed;
    logic [STALL_W-1:0] r_lstall, n_lstall;
    logic [STALL_W-1:0] r_rstall, n_rstall;
    t_spin_dir          r_spin_dir, n_spin_dir;
    logic [SPIN_W-1:0]  r_below, n_below;
    logic [SPIN_W-1:0]  r_reverse, n_reverse;
    logic [EXT_W-1:0]   r_extreme, n_extreme;
    logic [ANGLE_W-1:0] r_angle, n_angle;

    // per-tick operands
    logic [MAG_W-1:0]   tgt_max, spd_max;
    logic [MAG_W-1:0]   mag_lt, mag_rt, mag_ls, mag_rs, mag_ld, mag_rd, rate;
    logic [THR_W-1:0]   speed_sat;
    logic [PROD_W-1:0]  speed_x10, ref_x9;
    logic               lstall_cond, rstall_cond;
    t_spin_dir          yaw_dir;
    logic [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W-1:0] angle_sat;

    assign mag_lt = mag16(i_item.left_target);
    assign mag_rt = mag16(i_item.right_target);
    assign mag_ls = mag16(i_item.left_speed);
    assign mag_rs = mag16(i_item.right_speed);
    assign mag_ld = mag16(i_item.left_drive);
    assign mag_rd = mag16(i_item.right_drive);
    assign rate   = mag16(i_item.yaw_rate);

    assign tgt_max = (mag_lt > mag_rt) ? mag_lt : mag_rt;
    assign spd_max = (mag_ls > mag_rs) ? mag_ls : mag_rs;
    // only 32768 sets the top bits
    assign speed_sat = (spd_max[MAG_W-1] | spd_max[MAG_W-2]) ? '1 : spd_max[THR_W-1:0];
    // 10*peak >= 9*reference stands for peak >= 0.9*reference
    assign speed_x10 = (PROD_W'(spd_max) << 3) + (PROD_W'(spd_max) << 1);
    assign ref_x9    = (PROD_W'(r_ref_speed) << 3) + PROD_W'(r_ref_speed);

    assign lstall_cond = (mag_lt >= MAG_W'(i_cfg.stall_target_min)) &&
                         (mag_ls <= MAG_W'(i_cfg.stall_speed_max)) &&
                         (mag_ld >= MAG_W'(i_cfg.stall_drive_min));
    assign rstall_cond = (mag_rt >= MAG_W'(i_cfg.stall_target_min)) &&
                         (mag_rs <= MAG_W'(i_cfg.stall_speed_max)) &&
                         (mag_rd >= MAG_W'(i_cfg.stall_drive_min));

    assign yaw_dir   = i_item.yaw_rate[DATA_W-1] ? SPIN_NEG : SPIN_POS;
    assign angle_sum = (ANGLE_W+1)'(r_angle) + (ANGLE_W+1)'(rate);
    assign angle_sat = angle_sum[ANGLE_W] ? '1 : angle_sum[ANGLE_W-1:0];

    always_comb begin
        n_allowed     = r_allowed;
        n_rearm       = r_rearm;
        n_switch_prev = i_item.run_switch;
        n_fault       = r_fault;
        n_grace       = r_grace;
        n_trend       = r_trend;
        n_ref_speed   = r_ref_speed;
        n_lstall      = r_lstall;
        n_rstall      = r_rstall;
        n_spin_dir    = r_spin_dir;
        n_below       = r_below;
        n_reverse     = r_reverse;
        n_extreme     = r_extreme;
        n_angle       = r_angle;

        if (!i_item.link_ok) begin
            if (r_fault == FAULT_NONE) n_fault = FAULT_LINK;
            n_allowed = 1'b0;
            n_rearm   = 1'b0;
        end else if (!i_item.imu_ok) begin
            if (r_fault == FAULT_NONE) n_fault = FAULT_IMU;
            n_allowed = 1'b0;
            n_rearm   = 1'b0;
        end else if (i_item.maint_busy) begin
            if (r_fault == FAULT_NONE) n_fault = FAULT_MAINT;
            n_allowed = 1'b0;
            n_rearm   = 1'b0;
        end else if (!i_item.run_switch) begin
            n_allowed = 1'b0;
            n_rearm   = 1'b1;
        end else if (!r_allowed) begin
            if (!r_switch_prev && r_rearm) begin
                n_fault   = FAULT_NONE;
                n_allowed = 1'b1;
                n_rearm   = 1'b0;
            end
        end else begin
            // stop monitor: no deceleration after a stop command
            if (i_cfg.monitor_enable[MON_STOP]) begin
                if (tgt_max > MAG_W'(i_cfg.stop_target_max) ||
                    spd_max <= MAG_W'(i_cfg.moving_speed_min)) begin
                    n_grace     = '0;
                    n_trend     = '0;
                    n_ref_speed = '0;
                end else if (r_grace < GRACE_END) begin
                    n_grace = r_grace + GRACE_W'(1);
                    if (n_grace == GRACE_END) begin
                        n_ref_speed = speed_sat;
                        n_trend     = '0;
                    end
                end else begin
                    n_trend = r_trend + TREND_W'(1);
                    if (n_trend >= TREND_END) begin
                        if (speed_x10 >= ref_x9) begin
                            if (r_fault == FAULT_NONE) n_fault = FAULT_NODECEL;
                            n_allowed = 1'b0;
                            n_rearm   = 1'b0;
                        end else begin
                            n_ref_speed = speed_sat;
                            n_trend     = '0;
                        end
                    end
                end
            end

            // stall monitor, left wins when both trip together
            if (n_allowed && i_cfg.monitor_enable[MON_STALL]) begin
                if (lstall_cond) begin
                    if (r_lstall < STALL_END) n_lstall = r_lstall + STALL_W'(1);
                end else begin
                    n_lstall = '0;
                end
                if (rstall_cond) begin
                    if (r_rstall < STALL_END) n_rstall = r_rstall + STALL_W'(1);
                end else begin
                    n_rstall = '0;
                end
                if (n_lstall >= STALL_END) begin
                    if (r_fault == FAULT_NONE) n_fault = FAULT_LSTALL;
                    n_allowed = 1'b0;
                    n_rearm   = 1'b0;
                end else if (n_rstall >= STALL_END) begin
                    if (r_fault == FAULT_NONE) n_fault = FAULT_RSTALL;
                    n_allowed = 1'b0;
                    n_rearm   = 1'b0;
                end
            end

            // rotation monitor
            if (n_allowed && i_cfg.monitor_enable[MON_SPIN]) begin
                if (rate >= MAG_W'(i_cfg.extreme_rate_min)) begin
                    if (r_extreme < EXT_END) n_extreme = r_extreme + EXT_W'(1);
                end else begin
                    n_extreme = '0;
                end
                if (n_extreme >= EXT_END) begin
                    if (r_fault == FAULT_NONE) n_fault = FAULT_EXTREME;
                    n_allowed = 1'b0;
                    n_rearm   = 1'b0;
                end else if (rate < MAG_W'(i_cfg.spin_rate_min)) begin
                    if (r_below < SPIN_END) n_below = r_below + SPIN_W'(1);
                    if (n_below >= SPIN_END) begin
                        n_spin_dir = SPIN_NONE;
                        n_reverse  = '0;
                        n_angle    = '0;
                    end
                end else begin
                    n_below = '0;
                    if (r_spin_dir != SPIN_NONE && yaw_dir != r_spin_dir) begin
                        // reversal: count it, restart after enough ticks
                        if (r_reverse < SPIN_END) n_reverse = r_reverse + SPIN_W'(1);
                        if (n_reverse >= SPIN_END) begin
                            n_spin_dir = yaw_dir;
                            n_reverse  = '0;
                            n_angle    = '0;
                        end
                    end else begin
                        n_spin_dir = yaw_dir;
                        n_reverse  = '0;
                        n_angle    = angle_sat;
                        if (angle_sat >= ANGLE_LIM) begin
                            if (r_fault == FAULT_NONE) n_fault = FAULT_SPIN;
                            n_allowed = 1'b0;
                            n_rearm   = 1'b0;
                        end
                    end
                end
            end
        end

        // every path that drops or grants permission also clears the motion monitors
        if (!n_allowed || (!r_allowed && n_allowed)) begin
            n_grace     = '0;
            n_trend     = '0;
            n_ref_speed = '0;
            n_lstall    = '0;
            n_rstall    = '0;
            n_spin_dir  = SPIN_NONE;
            n_below     = '0;
            n_reverse   = '0;
            n_extreme   = '0;
            n_angle     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed     <= 1'b0;
            r_rearm       <= 1'b0;
            r_switch_prev <= 1'b0;
            r_fault       <= FAULT_NONE;
            r_grace       <= '0;
            r_trend       <= '0;
            r_ref_speed   <= '0;
            r_lstall      <= '0;
            r_rstall      <= '0;
            r_spin_dir    <= SPIN_NONE;
            r_below       <= '0;
            r_reverse     <= '0;
            r_extreme     <= '0;
            r_angle       <= '0;
        end else if (i_step) begin
            r_allowed     <= n_allowed;
            r_rearm       <= n_rearm;
            r_switch_prev <= n_switch_prev;
            r_fault       <= n_fault;
            r_grace       <= n_grace;
            r_trend       <= n_trend;
            r_ref_speed   <= n_ref_speed;
            r_lstall      <= n_lstall;
            r_rstall      <= n_rstall;
            r_spin_dir    <= n_spin_dir;
            r_below       <= n_below;
            r_reverse     <= n_reverse;
            r_extreme     <= n_extreme;
            r_angle       <= n_angle;
        end
    end

    assign o_result.drive_allowed = r_allowed;
    assign o_result.fault_code    = r_fault;
    assign o_result.rearm_armed   = r_rearm;

endmodule

// ===== hw/rtl/motor_safety_interlock.sv =====
// ---------------------------------------------------------------------------
// motor_safety_interlock
// Per-tick drive interlock with latched fault code and optional motion
// monitors (stop/no-decel, wheel stall, rotation).
// ---------------------------------------------------------------------------
// Usage:
//  i_in carries one tick of flags, wheel targets, speeds, drive outputs and
//  yaw rate; o_out returns drive permission, latched fault code and the
//  re-arm flag after that tick. Both are valid/ready channels.
//  Thresholds and monitor enables are written through i_cfg_we/i_cfg_idx/
//  i_cfg_wdata while no transaction is in flight; they reset to defaults
//  with all monitors off.
//  A tick accepted on i_in is held in the input register, and its result is
//  registered in the core state registers when o_out can advance; o_out.valid
//  rises with that result. Throughput is one tick per cycle while o_out is not
//  stalled; the interlock state updates in one pass of combinational logic.
//  Reset clears the state: drive blocked, no fault, not armed, both channel
//  registers empty. When o_out is stalled, the result holds, one more tick
//  waits in the input register, and i_in.ready drops after that.
// ---------------------------------------------------------------------------
module motor_safety_interlock
    import msi_pkg::*;
#(
    parameter int GRACE_TICKS      = DEF_GRACE_TICKS,
    parameter int TREND_TICKS      = DEF_TREND_TICKS,
    parameter int STALL_TICKS      = DEF_STALL_TICKS,
    parameter int EXTREME_TICKS    = DEF_EXTREME_TICKS,
    parameter int SPIN_RESET_TICKS = DEF_SPIN_RESET_TICKS,
    parameter int ANGLE_LIMIT_MDEG = DEF_ANGLE_LIMIT_MDEG
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    msi_in_if.sink               i_in,
    msi_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]     i_cfg_wdata
);

    t_cfg      cfg;
    t_out_item result;
    t_in_item  r_item;
    logic      r_in_valid;
    logic      r_out_valid;
    logic      advance;
    logic      step;
    logic      in_take;

    assign advance = !r_out_valid || o_out.ready;
    assign step    = r_in_valid && advance;
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.run_switch   <= i_in.run_switch;
            r_item.link_ok      <= i_in.link_ok;
            r_item.imu_ok       <= i_in.imu_ok;
            r_item.maint_busy   <= i_in.maint_busy;
            r_item.left_target  <= i_in.left_target;
            r_item.right_target <= i_in.right_target;
            r_item.left_speed   <= i_in.left_speed;
            r_item.right_speed  <= i_in.right_speed;
            r_item.left_drive   <= i_in.left_drive;
            r_item.right_drive  <= i_in.right_drive;
            r_item.yaw_rate     <= i_in.yaw_rate;
        end
    end

    msi_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // core state registers double as the output register
    msi_core #(
        .GRACE_TICKS      (GRACE_TICKS),
        .TREND_TICKS      (TREND_TICKS),
        .STALL_TICKS      (STALL_TICKS),
        .EXTREME_TICKS    (EXTREME_TICKS),
        .SPIN_RESET_TICKS (SPIN_RESET_TICKS),
        .ANGLE_LIMIT_MDEG (ANGLE_LIMIT_MDEG)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.drive_allowed = result.drive_allowed;
    assign o_out.fault_code    = result.fault_code;
    assign o_out.rearm_armed   = result.rearm_armed;

endmodule

// ===== hw/rtl/msi_checker.sv =====
// ---------------------------------------------------------------------------
// msi_checker
// Port-level assertions for the motor safety interlock.
// ---------------------------------------------------------------------------
module msi_checker
    import msi_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_drive_allowed,
    input logic [FAULT_W-1:0] i_fault_code,
    input logic               i_rearm_armed
);

    // permission is only granted with the fault cleared
    a_allowed_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_drive_allowed) |-> (i_fault_code == FAULT_NONE))
        else $error("drive allowed with a fault latched");

    // re-arm is consumed when drive is granted
    a_allowed_not_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_drive_allowed) |-> !i_rearm_armed)
        else $error("drive allowed while still armed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_drive_allowed) && $stable(i_fault_code) &&
             $stable(i_rearm_armed)))
        else $error("stalled result changed");

endmodule

bind motor_safety_interlock msi_checker u_msi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_drive_allowed (o_out.drive_allowed),
    .i_fault_code    (o_out.fault_code),
    .i_rearm_armed   (o_out.rearm_armed)
);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives tick transactions into the motor safety interlock and checks every
// verdict against an in-bench predictor of the interlock and its monitors.
// Directed scenarios cover switch re-arming, fault priority and each monitor
// trip. Random episodes then run under several threshold settings while both
// channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
    import msi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ERR_PRINT_MAX = 40;
    localparam int ANGLE_SAT = (1 << ANGLE_W) - 1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    typedef enum int {EP_NOISE, EP_STOP, EP_STALL, EP_SPIN} t_ep_kind;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [THR_W-1:0]   i_cfg_wdata;

    msi_in_if  tick_ch ();
    msi_out_if verdict_ch ();

    motor_safety_interlock uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_ch),
        .o_out       (verdict_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    t_cfg               cfg_now;
    logic               drive_en;
    logic               armed;
    logic               sw_last;
    t_fault             latched;
    logic [4:0]         grace_n;
    logic [4:0]         trend_n;
    logic [THR_W-1:0]   ref_spd;
    logic [5:0]         lstall_n;
    logic [5:0]         rstall_n;
    logic [1:0]         spin_dir;
    logic [3:0]         calm_n;
    logic [3:0]         reverse_n;
    logic [7:0]         extreme_n;
    logic [ANGLE_W-1:0] angle;

    t_out_item expected_verdicts[$];
    int        err_n = 0;
    int        sent_n = 0;
    int        cycle_n = 0;
    bit        steady = 1'b0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_n);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int magnitude(input logic signed [DATA_W-1:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function automatic int peak_of(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
        int ma, mb;
        ma = magnitude(a);
        mb = magnitude(b);
        return (ma > mb) ? ma : mb;
    endfunction

    function automatic void clear_stop();
        grace_n = '0;
        trend_n = '0;
        ref_spd = '0;
    endfunction

    function automatic void clear_spin();
        spin_dir  = DIR_NONE;
        calm_n    = '0;
        reverse_n = '0;
        extreme_n = '0;
        angle     = '0;
    endfunction

    function automatic void clear_monitors();
        clear_stop();
        lstall_n = '0;
        rstall_n = '0;
        clear_spin();
    endfunction

    function automatic void model_reset();
        cfg_now  = reset_settings();
        drive_en = 1'b0;
        armed    = 1'b0;
        sw_last  = 1'b0;
        latched  = FAULT_NONE;
        clear_monitors();
    endfunction

    function automatic void trip_with(input t_fault code);
        if (latched == FAULT_NONE)
            latched = code;
        drive_en = 1'b0;
        armed    = 1'b0;
        clear_monitors();
    endfunction

    function automatic void watch_stop(input t_in_item t);
        int tp, sp;
        tp = peak_of(t.left_target, t.right_target);
        sp = peak_of(t.left_speed, t.right_speed);
        if (tp > int'(cfg_now.stop_target_max) || sp <= int'(cfg_now.moving_speed_min)) begin
            clear_stop();
            return;
        end
        if (grace_n < DEF_GRACE_TICKS) begin
            grace_n++;
            if (grace_n == DEF_GRACE_TICKS) begin
                ref_spd = (sp > 32767) ? '1 : THR_W'(sp);
                trend_n = '0;
            end
            return;
        end
        trend_n++;
        if (trend_n < DEF_TREND_TICKS)
            return;
        // still at 90 percent or more of the reference after a full window
        if (10 * sp >= 9 * int'(ref_spd)) begin
            trip_with(FAULT_NODECEL);
            return;
        end
        ref_spd = (sp > 32767) ? '1 : THR_W'(sp);
        trend_n = '0;
    endfunction

    function automatic bit stalled(input logic signed [DATA_W-1:0] target,
                                   input logic signed [DATA_W-1:0] speed,
                                   input logic signed [DATA_W-1:0] drive);
        return magnitude(target) >= int'(cfg_now.stall_target_min) &&
               magnitude(speed) <= int'(cfg_now.stall_speed_max) &&
               magnitude(drive) >= int'(cfg_now.stall_drive_min);
    endfunction

    function automatic void watch_stall(input t_in_item t);
        if (stalled(t.left_target, t.left_speed, t.left_drive)) begin
            if (lstall_n < DEF_STALL_TICKS)
                lstall_n++;
        end else begin
            lstall_n = '0;
        end
        if (stalled(t.right_target, t.right_speed, t.right_drive)) begin
            if (rstall_n < DEF_STALL_TICKS)
                rstall_n++;
        end else begin
            rstall_n = '0;
        end
        if (lstall_n >= DEF_STALL_TICKS)
            trip_with(FAULT_LSTALL);
        else if (rstall_n >= DEF_STALL_TICKS)
            trip_with(FAULT_RSTALL);
    endfunction

    function automatic void watch_spin(input t_in_item t);
        int rate, sum;
        logic [1:0] dir;
        rate = magnitude(t.yaw_rate);
        dir  = t.yaw_rate[DATA_W-1] ? DIR_NEG : DIR_POS;
        if (rate >= int'(cfg_now.extreme_rate_min)) begin
            if (extreme_n < DEF_EXTREME_TICKS)
                extreme_n++;
        end else begin
            extreme_n = '0;
        end
        if (extreme_n >= DEF_EXTREME_TICKS) begin
            trip_with(FAULT_EXTREME);
            return;
        end
        if (rate < int'(cfg_now.spin_rate_min)) begin
            if (calm_n < DEF_SPIN_RESET_TICKS)
                calm_n++;
            if (calm_n >= DEF_SPIN_RESET_TICKS) begin
                spin_dir  = DIR_NONE;
                reverse_n = '0;
                angle     = '0;
            end
            return;
        end
        calm_n = '0;
        if (spin_dir == DIR_NONE) begin
            spin_dir = dir;
        end else if (dir != spin_dir) begin
            if (reverse_n < DEF_SPIN_RESET_TICKS)
                reverse_n++;
            if (reverse_n >= DEF_SPIN_RESET_TICKS) begin
                spin_dir  = dir;
                reverse_n = '0;
                angle     = '0;
            end
            return;
        end
        reverse_n = '0;
        sum = int'(angle) + rate;
        if (sum > ANGLE_SAT)
            sum = ANGLE_SAT;
        angle = ANGLE_W'(sum);
        if (sum >= DEF_ANGLE_LIMIT_MDEG)
            trip_with(FAULT_SPIN);
    endfunction

    function automatic void predict_verdict(input t_in_item t);
        logic rise;
        rise    = t.run_switch && !sw_last;
        sw_last = t.run_switch;
        if (!t.link_ok) begin
            trip_with(FAULT_LINK);
        end else if (!t.imu_ok) begin
            trip_with(FAULT_IMU);
        end else if (t.maint_busy) begin
            trip_with(FAULT_MAINT);
        end else if (!t.run_switch) begin
            drive_en = 1'b0;
            armed    = 1'b1;
            clear_monitors();
        end else if (!drive_en) begin
            if (rise && armed) begin
                latched  = FAULT_NONE;
                drive_en = 1'b1;
                armed    = 1'b0;
                clear_monitors();
            end
        end else begin
            if (cfg_now.monitor_enable[MON_STOP])
                watch_stop(t);
            if (drive_en && cfg_now.monitor_enable[MON_STALL])
                watch_stall(t);
            if (drive_en && cfg_now.monitor_enable[MON_SPIN])
                watch_spin(t);
        end
        expected_verdicts.push_back('{drive_allowed: drive_en, fault_code: latched,
                                      rearm_armed: armed});
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_cfg reset_settings();
        t_cfg s;
        s.monitor_enable   = RST_MONITOR_ENABLE;
        s.stop_target_max  = RST_STOP_TARGET_MAX;
        s.moving_speed_min = RST_MOVING_SPEED_MIN;
        s.stall_target_min = RST_STALL_TARGET_MIN;
        s.stall_speed_max  = RST_STALL_SPEED_MAX;
        s.stall_drive_min  = RST_STALL_DRIVE_MIN;
        s.spin_rate_min    = RST_SPIN_RATE_MIN;
        s.extreme_rate_min = RST_EXTREME_RATE_MIN;
        return s;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        s.monitor_enable   = MON_W'($urandom_range(0, 7));
        s.stop_target_max  = THR_W'($urandom_range(0, 200));
        s.moving_speed_min = THR_W'($urandom_range(0, 2000));
        s.stall_target_min = THR_W'($urandom_range(0, 5000));
        s.stall_speed_max  = THR_W'($urandom_range(0, 100));
        s.stall_drive_min  = THR_W'($urandom_range(0, 20000));
        s.spin_rate_min    = THR_W'($urandom_range(0, 8000));
        s.extreme_rate_min = THR_W'($urandom_range(0, 32767));
        return s;
    endfunction

    function automatic bit rsign();
        return 1'($urandom_range(0, 1));
    endfunction

    // magnitude 32768 can only be the most negative code
    function automatic logic [DATA_W-1:0] as_word(input int m, input bit neg);
        if (m >= 32768)
            return 16'h8000;
        return neg ? DATA_W'(-m) : DATA_W'(m);
    endfunction

    function automatic t_in_item plain_tick(input bit sw, input bit link = 1'b1,
                                            input bit imu = 1'b1, input bit maint = 1'b0);
        t_in_item t;
        t = '0;
        t.run_switch = sw;
        t.link_ok    = link;
        t.imu_ok     = imu;
        t.maint_busy = maint;
        return t;
    endfunction

    function automatic t_in_item level_tick(input logic [DATA_W-1:0] w);
        t_in_item t;
        t = plain_tick(1'b1);
        t.left_target  = w;
        t.right_target = w;
        t.left_speed   = w;
        t.right_speed  = w;
        t.left_drive   = w;
        t.right_drive  = w;
        t.yaw_rate     = w;
        return t;
    endfunction

    // random data; flags fully random when noisy, else all good when clean, else mostly good
    function automatic t_in_item random_tick(input bit noisy, input bit clean);
        t_in_item t;
        t.left_target  = DATA_W'($urandom);
        t.right_target = DATA_W'($urandom);
        t.left_speed   = DATA_W'($urandom);
        t.right_speed  = DATA_W'($urandom);
        t.left_drive   = DATA_W'($urandom);
        t.right_drive  = DATA_W'($urandom);
        t.yaw_rate     = DATA_W'($urandom);
        if (noisy) begin
            {t.run_switch, t.link_ok, t.imu_ok, t.maint_busy} = 4'($urandom);
        end else begin
            t.run_switch = clean || ($urandom_range(0, 39) != 0);
            t.link_ok    = clean || ($urandom_range(0, 59) != 0);
            t.imu_ok     = clean || ($urandom_range(0, 59) != 0);
            t.maint_busy = !clean && ($urandom_range(0, 59) == 0);
        end
        return t;
    endfunction

    task automatic drive_tick(input t_in_item t);
        tick_ch.run_switch   <= t.run_switch;
        tick_ch.link_ok      <= t.link_ok;
        tick_ch.imu_ok       <= t.imu_ok;
        tick_ch.maint_busy   <= t.maint_busy;
        tick_ch.left_target  <= t.left_target;
        tick_ch.right_target <= t.right_target;
        tick_ch.left_speed   <= t.left_speed;
        tick_ch.right_speed  <= t.right_speed;
        tick_ch.left_drive   <= t.left_drive;
        tick_ch.right_drive  <= t.right_drive;
        tick_ch.yaw_rate     <= t.yaw_rate;
    endtask

    // called at a rising edge; returns at the edge that took the transaction
    task automatic push_tick(input t_in_item t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        drive_tick(t);
        do @(posedge i_clk); while (!tick_ch.ready);
        predict_verdict(t);
        sent_n++;
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_verdicts.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg s);
        write_reg(CFG_MONITOR_ENABLE, THR_W'(s.monitor_enable));
        write_reg(CFG_STOP_TARGET_MAX, s.stop_target_max);
        write_reg(CFG_MOVING_SPEED_MIN, s.moving_speed_min);
        write_reg(CFG_STALL_TARGET_MIN, s.stall_target_min);
        write_reg(CFG_STALL_SPEED_MAX, s.stall_speed_max);
        write_reg(CFG_STALL_DRIVE_MIN, s.stall_drive_min);
        write_reg(CFG_SPIN_RATE_MIN, s.spin_rate_min);
        write_reg(CFG_EXTREME_RATE_MIN, s.extreme_rate_min);
        i_cfg_we <= 1'b0;
        cfg_now = s;
    endtask

    task automatic rearm();
        push_tick(plain_tick(1'b0));
        push_tick(plain_tick(1'b1));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_switch_and_faults();
        load_settings(reset_settings());
        push_tick(plain_tick(1'b1));                   // edge without switch seen off
        push_tick(plain_tick(1'b0));
        push_tick(plain_tick(1'b1));
        push_tick(plain_tick(1'b1, 1'b0, 1'b0, 1'b1)); // link loss has priority
        push_tick(plain_tick(1'b1, 1'b1, 1'b0, 1'b0)); // first fault stays latched
        push_tick(plain_tick(1'b1, 1'b1, 1'b1, 1'b1));
        push_tick(plain_tick(1'b1));
        push_tick(plain_tick(1'b0));
        push_tick(plain_tick(1'b0, 1'b1, 1'b0, 1'b0)); // trip while off drops arming
        push_tick(plain_tick(1'b0));
        push_tick(plain_tick(1'b1, 1'b0, 1'b1, 1'b0)); // edge consumed by a trip
        push_tick(plain_tick(1'b1));
        push_tick(plain_tick(1'b0));
        push_tick(level_tick(16'h8000));
        push_tick(level_tick(16'h7FFF));
        push_tick(level_tick(16'h8001));
        push_tick(plain_tick(1'b1, 1'b1, 1'b0, 1'b0));
        rearm();
        push_tick(plain_tick(1'b1, 1'b1, 1'b1, 1'b1));
        rearm();
        push_tick(random_tick(1'b0, 1'b1));
        push_tick(random_tick(1'b0, 1'b1));
        settle();
    endtask

    task automatic test_stop_monitor();
        t_cfg s;
        t_in_item t;
        int k, lvl;
        s = reset_settings();
        s.monitor_enable = 3'b001;
        load_settings(s);
        rearm();
        // steady speed after stop: grace, one trend window, then trip
        for (k = 0; k < 62; k++) begin
            t = plain_tick(1'b1);
            t.left_target  = 16'sd3;
            t.right_target = -16'sd5;
            t.left_speed   = -16'sd1000;
            t.right_speed  = 16'sd400;
            push_tick(t);
        end
        rearm();
        // peak of 32768 captured as a saturated reference, then a real deceleration
        lvl = 32768;
        for (k = 0; k < 100; k++) begin
            t = plain_tick(1'b1);
            t.left_speed  = as_word(lvl, 1'b1);
            t.right_speed = as_word(lvl / 2, 1'b0);
            if (k == 80)
                t.left_target = 16'sd6;
            push_tick(t);
            if (k >= 30)
                lvl = lvl - lvl / 50;
        end
        settle();
    endtask

    task automatic test_stall_monitor();
        t_cfg s;
        t_in_item t;
        int k;
        s = reset_settings();
        s.monitor_enable = 3'b010;
        load_settings(s);
        rearm();
        // both wheels stalled: left fault wins
        for (k = 0; k < 52; k++) begin
            t = plain_tick(1'b1);
            t.left_target  = 16'sd50;
            t.right_target = -16'sd60;
            t.left_speed   = -16'sd5;
            t.right_speed  = 16'sd5;
            t.left_drive   = 16'sd4800;
            t.right_drive  = -16'sd4800;
            push_tick(t);
        end
        rearm();
        for (k = 0; k < 51; k++) begin
            t = plain_tick(1'b1);
            t.right_target = 16'h8000;
            t.right_drive  = 16'h8000;
            t.left_target  = 16'sd49;
            t.left_drive   = 16'sd30000;
            push_tick(t);
        end
        rearm();
        // a break in the stall restarts the count
        for (k = 0; k < 82; k++) begin
            t = plain_tick(1'b1);
            t.left_target = -16'sd200;
            t.left_drive  = 16'sd6000;
            t.left_speed  = (k == 30) ? 16'sd6 : 16'sd0;
            push_tick(t);
        end
        settle();
    endtask

    task automatic test_spin_monitor();
        t_cfg s;
        t_in_item t;
        int k;
        s = reset_settings();
        s.monitor_enable = 3'b100;
        load_settings(s);
        rearm();
        for (k = 0; k < 34; k++) begin
            t = plain_tick(1'b1);
            t.yaw_rate = 16'sd32767;
            push_tick(t);
        end
        rearm();
        // rate drops below threshold long enough to clear the angle
        for (k = 0; k < 30; k++) begin
            t = plain_tick(1'b1);
            t.yaw_rate = (k >= 5 && k < 16) ? 16'sd100 : ((k < 5) ? 16'sd4000 : -16'sd4000);
            push_tick(t);
        end
        settle();
        // no angle accumulation, so only the extreme rate count can trip
        s.spin_rate_min = 15'h7FFF;
        load_settings(s);
        rearm();
        for (k = 0; k < 251; k++) begin
            t = plain_tick(1'b1);
            t.yaw_rate = -16'sd6000;
            push_tick(t);
        end
        settle();
        // zero yaw passes the rate test and counts as positive
        s.spin_rate_min = '0;
        load_settings(s);
        rearm();
        for (k = 0; k < 20; k++) begin
            t = plain_tick(1'b1);
            t.yaw_rate = (k < 4 || k >= 16) ? -16'sd100 : 16'sd0;
            push_tick(t);
        end
        settle();
    endtask

    task automatic random_episode(input t_ep_kind kind);
        t_in_item t;
        int len, k, lvl, decay, yaw_mag, stall_sel;
        bit yaw_neg, clean;
        steady    = ($urandom_range(0, 3) == 0);
        clean     = rsign();
        len       = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 270)
                                                : $urandom_range(4, 60);
        lvl       = $urandom_range(int'(cfg_now.moving_speed_min) + 1, 32768);
        decay     = $urandom_range(0, 3);
        yaw_mag   = rsign() ? $urandom_range(int'(cfg_now.spin_rate_min), 32768)
                            : $urandom_range(int'(cfg_now.extreme_rate_min), 32768);
        yaw_neg   = rsign();
        stall_sel = $urandom_range(1, 3);
        if (kind != EP_NOISE && $urandom_range(0, 7) != 0) begin
            t = random_tick(1'b0, 1'b1);
            t.run_switch = 1'b0;
            push_tick(t);
        end
        for (k = 0; k < len; k++) begin
            t = random_tick(kind == EP_NOISE, clean);
            case (kind)
                EP_STOP: begin
                    t.left_target  = as_word($urandom_range(0, cfg_now.stop_target_max), rsign());
                    t.right_target = as_word($urandom_range(0, cfg_now.stop_target_max), rsign());
                    t.left_speed   = as_word(lvl, rsign());
                    t.right_speed  = as_word($urandom_range(0, lvl), rsign());
                    lvl = lvl - lvl * decay / 100;
                end
                EP_STALL: begin
                    if (stall_sel[0] && $urandom_range(0, 29) != 0) begin
                        t.left_target = as_word($urandom_range(cfg_now.stall_target_min, 32768),
                                                rsign());
                        t.left_speed  = as_word($urandom_range(0, cfg_now.stall_speed_max),
                                                rsign());
                        t.left_drive  = as_word($urandom_range(cfg_now.stall_drive_min, 32768),
                                                rsign());
                    end
                    if (stall_sel[1] && $urandom_range(0, 29) != 0) begin
                        t.right_target = as_word($urandom_range(cfg_now.stall_target_min, 32768),
                                                 rsign());
                        t.right_speed  = as_word($urandom_range(0, cfg_now.stall_speed_max),
                                                 rsign());
                        t.right_drive  = as_word($urandom_range(cfg_now.stall_drive_min, 32768),
                                                 rsign());
                    end
                end
                EP_SPIN: begin
                    // lasting direction changes plus single reversed ticks
                    if ($urandom_range(0, 19) == 0)
                        yaw_neg = !yaw_neg;
                    if ($urandom_range(0, 9) == 0)
                        t.yaw_rate = as_word($urandom_range(0, cfg_now.spin_rate_min), rsign());
                    else
                        t.yaw_rate = as_word(yaw_mag, yaw_neg ^ ($urandom_range(0, 7) == 0));
                end
                default: ;
            endcase
            push_tick(t);
        end
    endtask

    task automatic test_random_traffic();
        t_cfg s;
        int phase, goal;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    s = reset_settings();
                    s.monitor_enable = 3'b111;
                end
                1: begin
                    s = '0;
                    s.monitor_enable = 3'b111;
                end
                2: begin
                    s = '1;
                end
                default: s = random_settings();
            endcase
            load_settings(s);
            goal = sent_n + 1;
            while (sent_n < goal)
                random_episode(t_ep_kind'($urandom_range(0, 3)));
            steady = 1'b0;
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls and field checks
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [FAULT_W-1:0] want,
                                   input logic [FAULT_W-1:0] got);
        err_n++;
        if (err_n <= ERR_PRINT_MAX)
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endtask

    task automatic check_verdict();
        t_out_item want;
        if (expected_verdicts.size() == 0) begin
            err_n++;
            if (err_n <= ERR_PRINT_MAX)
                $display("%0t: result with no transaction pending, expected none got %0b/%0d/%0b",
                         $time, verdict_ch.drive_allowed, verdict_ch.fault_code,
                         verdict_ch.rearm_armed);
            return;
        end
        want = expected_verdicts.pop_front();
        if (verdict_ch.drive_allowed !== want.drive_allowed)
            report_mismatch("drive_allowed", FAULT_W'(want.drive_allowed),
                            FAULT_W'(verdict_ch.drive_allowed));
        if (verdict_ch.fault_code !== want.fault_code)
            report_mismatch("fault_code", want.fault_code, verdict_ch.fault_code);
        if (verdict_ch.rearm_armed !== want.rearm_armed)
            report_mismatch("rearm_armed", FAULT_W'(want.rearm_armed),
                            FAULT_W'(verdict_ch.rearm_armed));
    endtask

    initial begin
        int pause;
        verdict_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            pause = steady ? 0 : $urandom_range(0, 9);
            if (pause > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!verdict_ch.valid);
            check_verdict();
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MONITOR_ENABLE;
        i_cfg_wdata   <= '0;
        tick_ch.valid <= 1'b0;
        drive_tick('0);
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_switch_and_faults();
        test_stop_monitor();
        test_stall_monitor();
        test_spin_monitor();
        test_random_traffic();

        settle();
        repeat (4) @(posedge i_clk);
        if (err_n == 0 && expected_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== motor_safety_interlock.f =====
hw/rtl/msi_pkg.sv
hw/rtl/msi_if.sv
hw/rtl/msi_cfg_regs.sv
hw/rtl/msi_core.sv
hw/rtl/motor_safety_interlock.sv
hw/rtl/msi_checker.sv
tb/testbench.sv
